### rtl/tfn_pkg.sv
// Shared types and constants for the triangle face normal unit.
package tfn_pkg;
   localparam int CoordWidth  = 24;
   localparam int DiffWidth   = 25;
   localparam int CrossWidth  = 51;
   localparam int DredWidth   = 31;
   localparam int SumWidth    = 64;
   localparam int OutWidth    = 16;
   localparam int MaxFracBits = 30;
   // Search residuals, sized for the widest fraction setting.
   localparam int ResWidth    = 2 * MaxFracBits + 68;

   // Data handed from one search cell to the next.
   typedef struct packed {
      logic                          valid;
      logic                          degenerate;
      logic [2:0]                    neg;
      logic [SumWidth-1:0]           s;
      logic [2:0][31:0]              q;
      logic [2:0][ResWidth-1:0]      h;
      logic [2:0][ResWidth-1:0]      e;
   } cell_data_type;
endpackage

### rtl/tfn_front.sv
// Front end: edge vectors, cross product, magnitude reduction and sum of squares.
module tfn_front #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic signed [tfn_pkg::CoordWidth-1:0]  ax, ay, az, bx, by_coord, bz, cx, cy, cz,
   output tfn_pkg::cell_data_type                 out_data
);
   localparam int DW = tfn_pkg::DiffWidth;
   localparam int CW = tfn_pkg::CrossWidth;
   localparam int RW = tfn_pkg::DredWidth;

   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic signed [DW-1:0] u_in [3];
   logic signed [DW-1:0] v_in [3];
   logic signed [2*DW-1:0] p_ff [6];
   logic signed [2*DW-1:0] p_in [6];
   logic signed [CW-1:0] c_ff [3];
   logic signed [CW-1:0] c_in [3];
   logic [CW-1:0] mag_ff [3];
   logic [CW-1:0] mag_in [3];
   logic [2:0] neg_ff, neg_in;
   logic [RW-1:0] d_ff [3];
   logic [RW-1:0] d_in [3];
   logic [2:0] neg2_ff;
   logic deg_ff, deg_in, deg2_ff;
   logic [tfn_pkg::SumWidth-1:0] sq_ff [3];
   logic [2:0] neg3_ff;
   logic deg3_ff;
   logic [5:0] vld_ff;
   logic [CW-1:0] m;
   logic [4:0] k;

   always_comb begin
      u_in[0] = DW'(bx) - DW'(ax);
      u_in[1] = DW'(by_coord) - DW'(ay);
      u_in[2] = DW'(bz) - DW'(az);
      v_in[0] = DW'(cx) - DW'(ax);
      v_in[1] = DW'(cy) - DW'(ay);
      v_in[2] = DW'(cz) - DW'(az);
      p_in[0] = u_ff[2] * v_ff[1];
      p_in[1] = u_ff[1] * v_ff[2];
      p_in[2] = u_ff[0] * v_ff[2];
      p_in[3] = u_ff[2] * v_ff[0];
      p_in[4] = u_ff[1] * v_ff[0];
      p_in[5] = u_ff[0] * v_ff[1];
      c_in[0] = CW'(p_ff[0]) - CW'(p_ff[1]);
      c_in[1] = CW'(p_ff[2]) - CW'(p_ff[3]);
      c_in[2] = CW'(p_ff[4]) - CW'(p_ff[5]);
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = c_ff[i][CW-1];
         mag_in[i] = neg_in[i] ? CW'(-c_ff[i]) : CW'(c_ff[i]);
      end
      deg_in = (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
      m = mag_ff[0] | mag_ff[1] | mag_ff[2];
      k = '0;
      for (int b = RW; b < CW; b++)
         if (m[b]) k = 5'(b - RW + 1);
      for (int i = 0; i < 3; i++)
         d_in[i] = RW'(mag_ff[i] >> k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
      if (enable) begin
         u_ff <= u_in;
         v_ff <= v_in;
         p_ff <= p_in;
         c_ff <= c_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         deg_ff <= deg_in;
         d_ff <= d_in;
         neg2_ff <= neg_ff;
         deg2_ff <= deg_ff;
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= tfn_pkg::SumWidth'(d_ff[i]) * tfn_pkg::SumWidth'(d_ff[i]);
         neg3_ff <= neg2_ff;
         deg3_ff <= deg2_ff;
      end
   end

   always_comb begin
      out_data.valid = vld_ff[5];
      out_data.degenerate = deg3_ff;
      out_data.neg = neg3_ff;
      out_data.s = sq_ff[0] + sq_ff[1] + sq_ff[2];
      // residual starts at d^2 * 2^(2F+2), the search state at q = 0
      for (int i = 0; i < 3; i++) begin
         out_data.q[i] = '0;
         out_data.h[i] = tfn_pkg::ResWidth'(sq_ff[i]) << (2 * FRAC_BITS + 2);
         out_data.e[i] = '0;
      end
   end
endmodule

### rtl/tfn_cell.sv
// One bit of the rounded quotient search for all three components.
module tfn_cell #(
   parameter int BIT = 0,
   parameter int FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  tfn_pkg::cell_data_type in_data,
   output tfn_pkg::cell_data_type out_data
);
   // q = largest with (2q-1)^2 * s <= d^2 * 2^(2F+2); bit BIT tried this cell.
   // h = d^2 * 2^(2F+2) - (2q-1)^2 * s + s and e = 2q * s, updated by shifts and adds.
   localparam int LW = 2 * FRAC_BITS + 68;
   localparam int RW = tfn_pkg::ResWidth;
   tfn_pkg::cell_data_type data_ff, data_in;
   logic [31:0] cand;
   logic [LW-1:0] s_w, h_w, e_w, step;

   always_comb begin
      data_in = in_data;
      s_w = LW'(in_data.s);
      for (int i = 0; i < 3; i++) begin
         cand = in_data.q[i] | (32'd1 << BIT);
         h_w = LW'(in_data.h[i]);
         e_w = LW'(in_data.e[i]);
         // growth of (2q-1)^2 * s when bit BIT is set
         step = (e_w << (BIT + 2)) + (s_w << (2 * BIT + 2)) - (s_w << (BIT + 2));
         if (h_w >= step + s_w && cand <= (32'd1 << FRAC_BITS)) begin
            data_in.q[i] = cand;
            data_in.h[i] = RW'(h_w - step);
            data_in.e[i] = RW'(e_w + (s_w << (BIT + 1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) data_ff.valid <= 1'b0;
      else if (enable) data_ff.valid <= data_in.valid;
      if (enable) begin
         data_ff.degenerate <= data_in.degenerate;
         data_ff.neg <= data_in.neg;
         data_ff.s <= data_in.s;
         data_ff.q <= data_in.q;
         data_ff.h <= data_in.h;
         data_ff.e <= data_in.e;
      end
   end
   assign out_data = data_ff;
endmodule

### rtl/triangle_face_normal_unit_top.sv
// Pipeline: 6 front stages, (NORMAL_FRAC_BITS+1) search cells and 1 output register.
// Throughput: one triangle per cycle while the result side does not stall the pipeline.
// A stall on the result side while a result is waiting freezes the whole pipeline; req_stall follows it.
// Reset (synchronous, active high) clears all valid bits and holds req_stall high.
module triangle_face_normal_unit_top #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [23:0] req_ax, req_ay, req_az,
   input  logic signed [23:0] req_bx, req_by_coord, req_bz,
   input  logic signed [23:0] req_cx, req_cy, req_cz,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_nx, rsp_ny, rsp_nz,
   output logic rsp_degenerate
);
   localparam int NC = NORMAL_FRAC_BITS + 1;
   tfn_pkg::cell_data_type chain [NC+1];
   logic enable;
   logic valid_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic deg_ff;
   tfn_pkg::cell_data_type last;

   assign enable = !(valid_ff && rsp_stall);
   assign req_stall = reset || !enable;

   tfn_front #(.FRAC_BITS(NORMAL_FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(req_valid),
      .ax(req_ax), .ay(req_ay), .az(req_az), .bx(req_bx), .by_coord(req_by_coord),
      .bz(req_bz), .cx(req_cx), .cy(req_cy), .cz(req_cz), .out_data(chain[0])
   );

   for (genvar g = 0; g < NC; g++) begin : g_cell
      tfn_cell #(.BIT(NC - 1 - g), .FRAC_BITS(NORMAL_FRAC_BITS)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .in_data(chain[g]), .out_data(chain[g+1])
      );
   end

   assign last = chain[NC];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (enable) valid_ff <= last.valid;
      if (enable) begin
         deg_ff <= last.degenerate;
         nx_ff <= last.degenerate ? '0 : (last.neg[0] ? -16'(last.q[0]) : 16'(last.q[0]));
         ny_ff <= last.degenerate ? '0 : (last.neg[1] ? -16'(last.q[1]) : 16'(last.q[1]));
         nz_ff <= last.degenerate ? '0 : (last.neg[2] ? -16'(last.q[2]) : 16'(last.q[2]));
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_nx = nx_ff;
   assign rsp_ny = ny_ff;
   assign rsp_nz = nz_ff;
   assign rsp_degenerate = deg_ff;
endmodule

### dv/testbench.sv
// Testbench for the triangle face normal unit: directed table plus random triangles.
`timescale 1ns / 1ps

module testbench;
   localparam int CoordW     = tfn_pkg::CoordWidth;
   localparam int OutW       = tfn_pkg::OutWidth;
   localparam int NormFrac   = 14;
   localparam int Unit       = 1 << NormFrac;
   localparam int CycleLimit = 200000;
   localparam int RandCount  = 1150;
   localparam int MaxC       = (1 << 23) - 1;
   localparam int MinC       = -(1 << 23);

   typedef struct {
      logic signed [CoordW-1:0] v [9];   // ax ay az bx by bz cx cy cz
      bit                       typed;
      logic signed [OutW-1:0]   nx, ny, nz;
      logic                     degenerate;
   } tri_row_type;

   typedef struct {
      logic signed [OutW-1:0] nx, ny, nz;
      logic                   degenerate;
   } normal_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [23:0] req_ax = 0, req_ay = 0, req_az = 0;
   logic signed [23:0] req_bx = 0, req_by_coord = 0, req_bz = 0;
   logic signed [23:0] req_cx = 0, req_cy = 0, req_cz = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_nx, rsp_ny, rsp_nz;
   logic rsp_degenerate;

   tri_row_type triangles [$];
   normal_type  pending_normals [$];
   tri_row_type cur_tri;
   bit       running = 0;
   int       next_idx = 0;
   int       n_accepted = 0;
   int       n_checked = 0;
   int       n_degenerate = 0;
   int       n_errors = 0;
   int       cycles = 0;
   int       send_idle_pct = 26;
   int       recv_idle_pct = 88;

   triangle_face_normal_unit_top #(.NORMAL_FRAC_BITS(NormFrac)) dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Rounded |d| * 2^F / sqrt(s), by binary search on the exact square.
   function automatic longint unsigned unit_component(longint unsigned d, longint unsigned s);
      logic [127:0]    target;
      logic [127:0]    lhs;
      longint unsigned lo, hi, mid, t;
      target = ({64'd0, d} * {64'd0, d}) << (2 * NormFrac + 2);
      lo = 0;
      hi = longint'(1) << NormFrac;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t = 2 * mid - 1;
         lhs = {64'd0, t * t} * {64'd0, s};
         if (lhs <= target) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic normal_type face_normal(tri_row_type tr);
      normal_type      r;
      longint          u [3], w [3], c [3];
      longint unsigned d [3], m, s, q;
      int              k;
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'(tr.v[3 + i]) - longint'(tr.v[i]);
         w[i] = longint'(tr.v[6 + i]) - longint'(tr.v[i]);
      end
      c[0] = u[2] * w[1] - u[1] * w[2];
      c[1] = u[0] * w[2] - u[2] * w[0];
      c[2] = u[1] * w[0] - u[0] * w[1];
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
         r = '{0, 0, 0, 1'b1};
         return r;
      end
      m = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = c[i] < 0 ? -c[i] : c[i];
         if (d[i] > m) m = d[i];
      end
      k = 0;
      while ((m >> k) >= (longint'(1) << 31)) k++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = d[i] >> k;
         s += d[i] * d[i];
      end
      q = unit_component(d[0], s); r.nx = c[0] < 0 ? -q[15:0] : q[15:0];
      q = unit_component(d[1], s); r.ny = c[1] < 0 ? -q[15:0] : q[15:0];
      q = unit_component(d[2], s); r.nz = c[2] < 0 ? -q[15:0] : q[15:0];
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic tri_row_type mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz);
      tri_row_type tr;
      tr.v = '{CoordW'(ax), CoordW'(ay), CoordW'(az), CoordW'(bx), CoordW'(by),
               CoordW'(bz), CoordW'(cx), CoordW'(cy), CoordW'(cz)};
      tr.typed = 0;
      tr.nx = 0; tr.ny = 0; tr.nz = 0; tr.degenerate = 0;
      return tr;
   endfunction

   function automatic tri_row_type with_exp(tri_row_type tr, int nx, int ny, int nz, bit dg);
      tr.typed = 1;
      tr.nx = OutW'(nx); tr.ny = OutW'(ny); tr.nz = OutW'(nz); tr.degenerate = dg;
      return tr;
   endfunction

   function automatic int rand_coord(int span);
      if (span == 0) return int'($urandom) <<< 8 >>> 8;
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic add_tri(tri_row_type tr);
      triangles.insert(triangles.size(), tr);
   endtask

   task automatic build_stimulus();
      tri_row_type tr;
      int       span, ax, ay, az, ux, uy, uz, f;
      // directed table
      add_tri(with_exp(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1));
      add_tri(with_exp(mk_tri(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC,
                              MaxC, MaxC, MaxC), 0, 0, 0, 1));
      add_tri(with_exp(mk_tri(MinC, MinC, MinC, MaxC, MaxC, MaxC,
                              0, 0, 0), 0, 0, 0, 1));
      add_tri(with_exp(mk_tri(0, 0, 0, 256, 0, 0, 0, 256, 0), 0, 0, -Unit, 0));
      add_tri(with_exp(mk_tri(0, 0, 0, 0, 256, 0, 0, 0, 256), -Unit, 0, 0, 0));
      add_tri(with_exp(mk_tri(0, 0, 0, 0, 0, 256, 256, 0, 0), 0, -Unit, 0, 0));
      add_tri(with_exp(mk_tri(0, 0, 0, 0, 256, 0, 256, 0, 0), 0, 0, Unit, 0));
      add_tri(with_exp(mk_tri(MinC, MinC, MinC, MaxC, MinC, MinC,
                              MinC, MaxC, MinC), 0, 0, -Unit, 0));
      add_tri(with_exp(mk_tri(MaxC, MaxC, MaxC, MinC, MaxC, MaxC,
                              MaxC, MinC, MaxC), 0, 0, -Unit, 0));
      add_tri(with_exp(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, 0, -Unit, 0));
      add_tri(mk_tri(MinC, MaxC, MinC, MaxC, MinC, MaxC, MaxC, MaxC, MinC));
      add_tri(mk_tri(MaxC, MinC, MaxC, MinC, MaxC, MinC, MinC, MinC, MaxC));
      add_tri(mk_tri(MinC, MinC, MaxC, MaxC, MaxC, MinC, MinC, MaxC, MaxC));
      add_tri(mk_tri(0, 0, 0, 256, 0, 0, 0, 256, 256));
      add_tri(mk_tri(0, 0, 0, 256, 256, 256, -256, 256, 0));
      add_tri(mk_tri(5, -7, 3, 6, -7, 3, 5, -6, 4));
      add_tri(mk_tri(-1, -1, -1, 0, 0, 0, 1, 0, -1));
      add_tri(mk_tri(100, 200, 300, 100, 203, 304, 105, 200, 300));
      add_tri(mk_tri(MaxC, 0, MinC, MaxC - 3, 1, MinC + 4, MaxC, 2, MinC + 1));
      // random part: full range, local, tiny and collinear triangles
      for (int n = 0; n < RandCount; n++) begin
         f = int'($urandom_range(99));
         if (f < 35) begin
            for (int i = 0; i < 9; i++) tr.v[i] = CoordW'($urandom);
         end else begin
            span = f < 60 ? 4096 : (f < 80 ? 8 : 1 << $urandom_range(20));
            ax = rand_coord(0); ay = rand_coord(0); az = rand_coord(0);
            tr.v[0] = CoordW'(ax); tr.v[1] = CoordW'(ay); tr.v[2] = CoordW'(az);
            if (f < 90) begin
               for (int i = 3; i < 9; i++)
                  tr.v[i] = CoordW'(int'(tr.v[i % 3]) + rand_coord(span));
            end else begin
               // collinear: c = a + 2(b - a)
               ux = rand_coord(64); uy = rand_coord(64); uz = rand_coord(64);
               tr.v[3] = CoordW'(ax + ux); tr.v[4] = CoordW'(ay + uy);
               tr.v[5] = CoordW'(az + uz);
               tr.v[6] = CoordW'(ax + 2 * ux); tr.v[7] = CoordW'(ay + 2 * uy);
               tr.v[8] = CoordW'(az + 2 * uz);
            end
         end
         tr.typed = 0;
         add_tri(tr);
      end
   endtask

   // Sender: one transfer per accept, payload held while stalled.
   always @(posedge clock) begin
      if (running) begin
         if (req_valid && !req_stall) begin
            pending_normals.insert(pending_normals.size(), cur_tri.typed ?
               normal_type'{cur_tri.nx, cur_tri.ny, cur_tri.nz, cur_tri.degenerate} :
               face_normal(cur_tri));
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (next_idx < triangles.size() && $urandom_range(99) >= send_idle_pct) begin
               cur_tri = triangles[next_idx];
               next_idx++;
               req_ax <= cur_tri.v[0]; req_ay <= cur_tri.v[1]; req_az <= cur_tri.v[2];
               req_bx <= cur_tri.v[3]; req_by_coord <= cur_tri.v[4]; req_bz <= cur_tri.v[5];
               req_cx <= cur_tri.v[6]; req_cy <= cur_tri.v[7]; req_cz <= cur_tri.v[8];
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Receiver: check each transfer against the oldest prediction.
   always @(posedge clock) begin
      normal_type e;
      if (running) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_normals.size() == 0) begin
               $error("result with no triangle outstanding");
               n_errors++;
            end else begin
               e = pending_normals.pop_front();
               n_checked++;
               if (e.degenerate) n_degenerate++;
               if (rsp_nx !== e.nx) begin
                  $error("nx: expected %0d, got %0d", e.nx, rsp_nx); n_errors++;
               end
               if (rsp_ny !== e.ny) begin
                  $error("ny: expected %0d, got %0d", e.ny, rsp_ny); n_errors++;
               end
               if (rsp_nz !== e.nz) begin
                  $error("nz: expected %0d, got %0d", e.nz, rsp_nz); n_errors++;
               end
               if (rsp_degenerate !== e.degenerate) begin
                  $error("degenerate: expected %0d, got %0d", e.degenerate, rsp_degenerate);
                  n_errors++;
               end
            end
         end
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
         // idle mix by thirds of the stimulus
         if (next_idx * 3 >= triangles.size() * 2) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (next_idx * 3 >= triangles.size()) begin
            send_idle_pct = 88; recv_idle_pct = 26;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 0;
      running = 1;
      wait (n_accepted == triangles.size());
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_normals.size() != 0) n_errors++;
      $display("Covered %0d triangles, %0d results checked, %0d degenerate.",
               triangles.size(), n_checked, n_degenerate);
      if (n_errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

### files.f
rtl/tfn_pkg.sv
rtl/tfn_front.sv
rtl/tfn_cell.sv
rtl/triangle_face_normal_unit_top.sv
dv/testbench.sv
